[hdl/bk_pkg.sv]
// Shared types, codes and sizes for the deadlock-avoidance request checker.
package bk_pkg;

  localparam int MAX_PROCS     = 4;
  localparam int MAX_RESOURCES = 4;
  localparam int AMOUNT_BITS   = 8;
  localparam int PROC_BITS     = 2;
  localparam int COUNT_BITS    = 3;
  localparam int CFG_BITS      = 3;
  localparam int IN_LANES      = 4;
  localparam int IN_AMT_BITS   = 8;

  typedef logic [PROC_BITS-1:0]  proc_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_BITS-1:0]   cfg_val_t;

  typedef enum logic [1:0] {
    CMD_LOAD_MAX   = 2'd0,
    CMD_LOAD_ALLOC = 2'd1,
    CMD_SET_AVAIL  = 2'd2,
    CMD_REQUEST    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NEED  = 2'd1,
    STAT_AVAIL = 2'd2
  } status_t;

  typedef enum logic {
    CFG_PROCS     = 1'b0,
    CFG_RESOURCES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic  en;
    proc_t addr;
  } row_wr_t;

endpackage

[hdl/bk_row_mem.sv]
// Per-process row memory with registered read and row valid bits.
module bk_row_mem #(
  parameter int WIDTH = bk_pkg::MAX_RESOURCES * bk_pkg::AMOUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bk_pkg::row_wr_t  wr,
  input  logic [WIDTH-1:0] wdata,
  input  bk_pkg::proc_t    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0]            mem [bk_pkg::MAX_PROCS];
  logic [bk_pkg::MAX_PROCS-1:0] vld_r;
  logic [WIDTH-1:0]            rdata_r;
  logic                        rvld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

[hdl/bankers_request_and_safety_check.sv]
// Top level of the request checker: command sequencer, safety scan and channels.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   cmd, process, amount_0..amount_3
//   out_     output     out_valid/out_stall status, safe, finish_count, order_0..order_3
//   cfg_     input      cfg_valid/cfg_ready index, data (procs_in_use, resources_in_use)
//
// A load or set command passes through three steps: accept, row read, result.
// A granted request adds the safety scan, one row per cycle from the registered
// row memories, over the np processes in use.
// Reset clears the row valid bits, the available vector and the control state.
// A result waits in the output register while the next item is taken in.
module bankers_request_and_safety_check #(
  parameter int MAX_RESOURCES = bk_pkg::MAX_RESOURCES,
  parameter int AMOUNT_BITS   = bk_pkg::AMOUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic [bk_pkg::PROC_BITS-1:0]   in_process,
  input  logic [bk_pkg::IN_AMT_BITS-1:0] in_amount_0,
  input  logic [bk_pkg::IN_AMT_BITS-1:0] in_amount_1,
  input  logic [bk_pkg::IN_AMT_BITS-1:0] in_amount_2,
  input  logic [bk_pkg::IN_AMT_BITS-1:0] in_amount_3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic                           out_safe,
  output logic [bk_pkg::COUNT_BITS-1:0]  out_finish_count,
  output logic [bk_pkg::PROC_BITS-1:0]   out_order_0,
  output logic [bk_pkg::PROC_BITS-1:0]   out_order_1,
  output logic [bk_pkg::PROC_BITS-1:0]   out_order_2,
  output logic [bk_pkg::PROC_BITS-1:0]   out_order_3,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [bk_pkg::CFG_BITS-1:0]    cfg_data
);

  localparam int ROW_W = MAX_RESOURCES * AMOUNT_BITS;

  typedef logic [AMOUNT_BITS-1:0] amt_t;
  typedef amt_t [MAX_RESOURCES-1:0] row_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  function automatic amt_t sat_add(amt_t a, amt_t b);
    logic [AMOUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AMOUNT_BITS] ? '1 : s[AMOUNT_BITS-1:0];
  endfunction

  state_t state_r, state_nxt;

  bk_pkg::cfg_val_t procs_r, res_r;
  bk_pkg::count_t   np_w, nr_w;
  logic [MAX_RESOURCES-1:0] lane_on;

  bk_pkg::cmd_t  cmd_r;
  bk_pkg::proc_t proc_r;
  row_t          amt_r;
  row_t          avail_r, avail_nxt;
  row_t          work_r, work_nxt;

  bk_pkg::status_t status_r, status_nxt;
  logic            safe_r, safe_nxt;
  bk_pkg::count_t  count_r, count_nxt;
  bk_pkg::count_t  idle_r, idle_nxt;
  bk_pkg::proc_t   order_r [bk_pkg::MAX_PROCS];
  bk_pkg::proc_t   order_nxt [bk_pkg::MAX_PROCS];
  logic [bk_pkg::MAX_PROCS-1:0] done_r, done_nxt;

  bk_pkg::proc_t iss_pos_r, iss_pos_nxt;
  bk_pkg::proc_t eval_pos_r, eval_pos_nxt;
  logic          dvalid_r, dvalid_nxt;

  logic [bk_pkg::IN_AMT_BITS-1:0] in_amt [bk_pkg::IN_LANES];

  bk_pkg::row_wr_t alloc_wr, need_wr;
  bk_pkg::proc_t   raddr;
  row_t            alloc_rd, need_rd, alloc_wd, need_wd;
  logic [ROW_W-1:0] alloc_rd_bits, need_rd_bits;

  logic in_xfer, out_free;
  logic out_valid_r;
  bk_pkg::status_t out_status_r;
  logic            out_safe_r;
  bk_pkg::count_t  out_count_r;
  bk_pkg::proc_t   out_order_r [bk_pkg::MAX_PROCS];

  assign in_amt[0] = in_amount_0;
  assign in_amt[1] = in_amount_1;
  assign in_amt[2] = in_amount_2;
  assign in_amt[3] = in_amount_3;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (procs_r == '0) begin
      np_w = bk_pkg::count_t'(1);
    end else if (procs_r > bk_pkg::cfg_val_t'(bk_pkg::MAX_PROCS)) begin
      np_w = bk_pkg::count_t'(bk_pkg::MAX_PROCS);
    end else begin
      np_w = bk_pkg::count_t'(procs_r);
    end
    if (res_r == '0) begin
      nr_w = bk_pkg::count_t'(1);
    end else if (res_r > bk_pkg::cfg_val_t'(MAX_RESOURCES)) begin
      nr_w = bk_pkg::count_t'(MAX_RESOURCES);
    end else begin
      nr_w = bk_pkg::count_t'(res_r);
    end
    for (int r = 0; r < MAX_RESOURCES; r++) begin
      lane_on[r] = (bk_pkg::count_t'(r) < nr_w);
    end
  end

  assign raddr    = (state_r == ST_IDLE) ? in_process : iss_pos_r;
  assign alloc_rd = row_t'(alloc_rd_bits);
  assign need_rd  = row_t'(need_rd_bits);

  bk_row_mem #(.WIDTH(ROW_W)) u_alloc_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (alloc_wr),
    .wdata (ROW_W'(alloc_wd)),
    .raddr (raddr),
    .rdata (alloc_rd_bits)
  );

  bk_row_mem #(.WIDTH(ROW_W)) u_need_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (need_wr),
    .wdata (ROW_W'(need_wd)),
    .raddr (raddr),
    .rdata (need_rd_bits)
  );

  always_comb begin
    logic           fits;
    logic           refuse_need;
    bk_pkg::count_t cnt_up;
    bk_pkg::count_t idl_up;
    bk_pkg::count_t iss_up;

    state_nxt    = state_r;
    avail_nxt    = avail_r;
    work_nxt     = work_r;
    status_nxt   = status_r;
    safe_nxt     = safe_r;
    count_nxt    = count_r;
    idle_nxt     = idle_r;
    order_nxt    = order_r;
    done_nxt     = done_r;
    iss_pos_nxt  = iss_pos_r;
    eval_pos_nxt = eval_pos_r;
    dvalid_nxt   = dvalid_r;
    alloc_wr     = '{en: 1'b0, addr: proc_r};
    need_wr      = '{en: 1'b0, addr: proc_r};
    alloc_wd     = alloc_rd;
    need_wd      = need_rd;
    fits         = 1'b0;
    refuse_need  = 1'b0;
    cnt_up       = count_r + bk_pkg::count_t'(1);
    idl_up       = idle_r + bk_pkg::count_t'(1);
    iss_up       = {1'b0, iss_pos_r} + bk_pkg::count_t'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          status_nxt = bk_pkg::STAT_OK;
          safe_nxt   = 1'b0;
          count_nxt  = '0;
          idle_nxt   = '0;
          done_nxt   = '0;
          for (int k = 0; k < bk_pkg::MAX_PROCS; k++) begin
            order_nxt[k] = '0;
          end
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_OUT;
        unique case (cmd_r)
          bk_pkg::CMD_LOAD_MAX: begin
            need_wr.en = 1'b1;
            for (int r = 0; r < MAX_RESOURCES; r++) begin
              if (lane_on[r]) begin
                need_wd[r] = amt_r[r];
              end
            end
          end
          bk_pkg::CMD_LOAD_ALLOC: begin
            alloc_wr.en = 1'b1;
            need_wr.en  = 1'b1;
            for (int r = 0; r < MAX_RESOURCES; r++) begin
              if (lane_on[r]) begin
                alloc_wd[r] = amt_r[r];
                need_wd[r]  = (need_rd[r] > amt_r[r]) ? need_rd[r] - amt_r[r] : '0;
              end
            end
          end
          bk_pkg::CMD_SET_AVAIL: begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
              if (lane_on[r]) begin
                avail_nxt[r] = amt_r[r];
              end
            end
          end
          bk_pkg::CMD_REQUEST: begin
            if ({1'b0, proc_r} >= np_w) begin
              refuse_need = 1'b1;
              status_nxt  = bk_pkg::STAT_NEED;
            end else begin
              for (int r = MAX_RESOURCES - 1; r >= 0; r--) begin
                if (lane_on[r] && amt_r[r] > need_rd[r]) begin
                  status_nxt = bk_pkg::STAT_NEED;
                end else if (lane_on[r] && amt_r[r] > avail_r[r]) begin
                  status_nxt = bk_pkg::STAT_AVAIL;
                end
              end
            end
            if (!refuse_need && status_nxt == bk_pkg::STAT_OK) begin
              alloc_wr.en = 1'b1;
              need_wr.en  = 1'b1;
              for (int r = 0; r < MAX_RESOURCES; r++) begin
                if (lane_on[r]) begin
                  alloc_wd[r]  = sat_add(alloc_rd[r], amt_r[r]);
                  need_wd[r]   = need_rd[r] - amt_r[r];
                  avail_nxt[r] = avail_r[r] - amt_r[r];
                end
              end
              work_nxt    = avail_nxt;
              iss_pos_nxt = '0;
              dvalid_nxt  = 1'b0;
              state_nxt   = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        iss_pos_nxt  = (iss_up < np_w) ? iss_up[bk_pkg::PROC_BITS-1:0] : '0;
        eval_pos_nxt = iss_pos_r;
        dvalid_nxt   = 1'b1;
        if (dvalid_r) begin
          fits = !done_r[eval_pos_r];
          for (int r = 0; r < MAX_RESOURCES; r++) begin
            if (lane_on[r] && need_rd[r] > work_r[r]) begin
              fits = 1'b0;
            end
          end
          if (fits) begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
              if (lane_on[r]) begin
                work_nxt[r] = sat_add(work_r[r], alloc_rd[r]);
              end
            end
            done_nxt[eval_pos_r] = 1'b1;
            order_nxt[count_r[bk_pkg::PROC_BITS-1:0]] = eval_pos_r;
            count_nxt = cnt_up;
            idle_nxt  = '0;
          end else begin
            idle_nxt = idl_up;
          end
          if (count_nxt == np_w || idle_nxt == np_w) begin
            safe_nxt  = (count_nxt == np_w);
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      procs_r     <= bk_pkg::cfg_val_t'(3);
      res_r       <= bk_pkg::cfg_val_t'(3);
      avail_r     <= '0;
      out_valid_r <= 1'b0;
      dvalid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      avail_r  <= avail_nxt;
      dvalid_r <= dvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (bk_pkg::cfg_idx_t'(cfg_index))
          bk_pkg::CFG_PROCS:     procs_r <= cfg_data;
          bk_pkg::CFG_RESOURCES: res_r   <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= bk_pkg::cmd_t'(in_cmd);
      proc_r <= in_process;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        amt_r[r] <= AMOUNT_BITS'(in_amt[r]);
      end
    end
    work_r     <= work_nxt;
    status_r   <= status_nxt;
    safe_r     <= safe_nxt;
    count_r    <= count_nxt;
    idle_r     <= idle_nxt;
    order_r    <= order_nxt;
    done_r     <= done_nxt;
    iss_pos_r  <= iss_pos_nxt;
    eval_pos_r <= eval_pos_nxt;
    if (state_r == ST_OUT && out_free) begin
      out_status_r <= status_r;
      out_safe_r   <= safe_r;
      out_count_r  <= count_r;
      out_order_r  <= order_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_safe         = out_safe_r;
  assign out_finish_count = out_count_r;
  assign out_order_0      = out_order_r[0];
  assign out_order_1      = out_order_r[1];
  assign out_order_2      = out_order_r[2];
  assign out_order_3      = out_order_r[3];

endmodule
